FILE: src/round_robin_voice_allocator_assert.svh
// assertion macros used by the voice allocator checker
// no dependencies; include by bare file name
`ifndef ROUND_ROBIN_VOICE_ALLOCATOR_ASSERT_SVH
`define ROUND_ROBIN_VOICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RRVA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voice allocator assertion failed");

// next-cycle implication, disabled while in reset
`define RRVA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voice allocator assertion failed");

`endif

FILE: src/rrva_pkg.sv
// shared constants and controller/datapath interface types of the voice allocator
// no dependencies
`default_nettype none

package rrva_pkg;

    localparam int NUM_VOICES  = 12;
    localparam int NUM_GROUPS  = 12;
    localparam int VOICE_W     = 4;
    localparam int GROUP_W     = 4;
    localparam int PORT_W      = 2;
    localparam int CHANNEL_W   = 4;
    localparam int KEY_W       = 7;
    localparam int TRIG_W      = 13;
    localparam int MAP_NIB_W   = 4;
    localparam int MAP_W       = 48;
    localparam int LEGATO_W    = 12;
    localparam int CFG_IDX_W   = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_GROUP_MAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEGATO_GROUPS   = 1'b1;

    // action codes
    localparam logic ACT_ASSIGN = 1'b0;
    localparam logic ACT_WRITE  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic write_entry;
        logic init_scan;
        logic step;
        logic grant;
        logic steal;
        logic emit;
        logic emit_zero;
    } rrva_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_write;
        logic group_bad;
        logic match1;
        logic match2;
        logic last_step;
    } rrva_status_t;

endpackage

`default_nettype wire

FILE: src/rrva_ctrl.sv
// sequencing controller of the voice allocator: setup, first pass, second pass
// depends on rrva_pkg
`default_nettype none

module rrva_ctrl
    import rrva_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire rrva_status_t status,
    output rrva_cmd_t         cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PASS1,
        ST_PASS2
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (status.is_write)
                begin
                    cmd.write_entry = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_zero   = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (status.group_bad)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.init_scan = 1'b1;
                    state_next    = ST_PASS1;
                end
            end
            ST_PASS1:
            begin
                if (status.match1)
                begin
                    cmd.grant  = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (status.last_step)
                    begin
                        state_next = ST_PASS2;
                    end
                end
            end
            ST_PASS2:
            begin
                if (status.match2)
                begin
                    cmd.grant  = 1'b1;
                    cmd.steal  = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.last_step)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
        done_next = cmd.emit;
    end

    // state and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: src/rrva_datapath.sv
// voice table, per-group round-robin pointers, scan pointer and result registers
// depends on rrva_pkg
`default_nettype none

module rrva_datapath
    import rrva_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rrva_cmd_t            cmd,
    output rrva_status_t              status,
    input  wire logic                 action,
    input  wire logic [GROUP_W-1:0]   group,
    input  wire logic [PORT_W-1:0]    port,
    input  wire logic [CHANNEL_W-1:0] channel,
    input  wire logic [KEY_W-1:0]     key,
    input  wire logic [VOICE_W-1:0]   voice_index,
    input  wire logic                 entry_assigned,
    input  wire logic                 entry_held,
    input  wire logic [TRIG_W-1:0]    entry_trigger,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MAP_W-1:0]     cfg_data,
    output logic                      granted,
    output logic [VOICE_W-1:0]        chosen_voice,
    output logic [TRIG_W-1:0]         trigger,
    output logic [KEY_W-1:0]          note_key,
    output logic                      stolen,
    output logic                      legato
);

    // configuration registers
    logic [MAP_W-1:0]    group_map_reg;
    logic [LEGATO_W-1:0] legato_reg;

    // captured transaction
    logic                 action_reg;
    logic [GROUP_W-1:0]   group_reg;
    logic [TRIG_W-1:0]    trig_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VOICE_W-1:0]   vidx_reg;
    logic                 ent_assigned_reg;
    logic                 ent_held_reg;
    logic [TRIG_W-1:0]    ent_trig_reg;

    // voice table and per-group last voice
    logic                 assigned_reg [NUM_VOICES];
    logic                 held_reg     [NUM_VOICES];
    logic [TRIG_W-1:0]    vtrig_reg    [NUM_VOICES];
    logic [VOICE_W-1:0]   last_voice_reg [NUM_GROUPS];

    // scan pointer and step count
    logic [VOICE_W-1:0]   vp_reg, vp_next;
    logic [VOICE_W-1:0]   count_reg;

    // result registers
    logic                 granted_reg;
    logic [VOICE_W-1:0]   chosen_reg;
    logic [TRIG_W-1:0]    trigger_reg;
    logic [KEY_W-1:0]     note_key_reg;
    logic                 stolen_reg;
    logic                 legato_out_reg;

    logic [MAP_NIB_W-1:0] owner_arr [NUM_VOICES];
    logic [MAP_NIB_W-1:0] owner;
    logic [GROUP_W:0]     want_wide;
    logic [VOICE_W:0]     lv_inc;
    logic [VOICE_W:0]     vp_inc;
    logic [VOICE_W-1:0]   start_ptr;
    logic                 owned;
    logic                 leg_cond;
    logic                 vidx_ok;

    // owner nibble of each voice
    always_comb
    begin
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            owner_arr[v] = group_map_reg[v*MAP_NIB_W +: MAP_NIB_W];
        end
    end

    assign owner     = owner_arr[vp_reg];
    assign want_wide = {1'b0, group_reg} + (GROUP_W+1)'(1);
    assign owned     = (owner == want_wide[MAP_NIB_W-1:0]);

    // round-robin start after the group's last voice, and the wrapping step
    assign lv_inc    = {1'b0, last_voice_reg[group_reg]} + (VOICE_W+1)'(1);
    assign start_ptr = (lv_inc > (VOICE_W+1)'(NUM_VOICES - 1)) ? '0 : lv_inc[VOICE_W-1:0];
    assign vp_inc    = {1'b0, vp_reg} + (VOICE_W+1)'(1);
    assign vp_next   = (vp_inc > (VOICE_W+1)'(NUM_VOICES - 1)) ? '0 : vp_inc[VOICE_W-1:0];

    assign leg_cond  = legato_reg[group_reg] && assigned_reg[vp_reg]
                       && (vtrig_reg[vp_reg] != trig_reg);
    assign vidx_ok   = ({1'b0, vidx_reg} < (VOICE_W+1)'(NUM_VOICES));

    // status toward the controller
    always_comb
    begin
        status.is_write  = (action_reg == ACT_WRITE);
        status.group_bad = (group_reg > GROUP_W'(NUM_GROUPS - 1));
        status.match1    = owned && !assigned_reg[vp_reg];
        status.match2    = owned && (!assigned_reg[vp_reg] || !held_reg[vp_reg]);
        status.last_step = (count_reg == VOICE_W'(NUM_VOICES - 1));
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_map_reg <= '0;
            legato_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VOICE_GROUP_MAP: group_map_reg <= cfg_data;
                CFG_LEGATO_GROUPS:   legato_reg    <= cfg_data[LEGATO_W-1:0];
                default:             ;
            endcase
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg       <= action;
            group_reg        <= group;
            trig_reg         <= {port, channel, key};
            key_reg          <= key;
            vidx_reg         <= voice_index;
            ent_assigned_reg <= entry_assigned;
            ent_held_reg     <= entry_held;
            ent_trig_reg     <= entry_trigger;
        end
    end

    // scan pointer and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.init_scan)
        begin
            vp_reg    <= start_ptr;
            count_reg <= '0;
        end
        else if (cmd.step)
        begin
            vp_reg    <= vp_next;
            count_reg <= status.last_step ? '0 : count_reg + VOICE_W'(1);
        end
    end

    // voice table updates from host writes and grants
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                assigned_reg[v] <= 1'b0;
                held_reg[v]     <= 1'b0;
                vtrig_reg[v]    <= '0;
            end
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                last_voice_reg[g] <= '0;
            end
        end
        else if (cmd.write_entry)
        begin
            if (vidx_ok)
            begin
                assigned_reg[vidx_reg] <= ent_assigned_reg;
                held_reg[vidx_reg]     <= ent_held_reg;
                vtrig_reg[vidx_reg]    <= ent_trig_reg;
            end
        end
        else if (cmd.grant)
        begin
            assigned_reg[vp_reg]      <= 1'b1;
            held_reg[vp_reg]          <= 1'b1;
            vtrig_reg[vp_reg]         <= trig_reg;
            last_voice_reg[group_reg] <= vp_reg;
        end
    end

    // result registers, loaded once per transaction
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            granted_reg    <= cmd.grant;
            chosen_reg     <= cmd.grant ? vp_reg : '0;
            trigger_reg    <= cmd.emit_zero ? '0 : trig_reg;
            note_key_reg   <= cmd.emit_zero ? '0 : key_reg;
            stolen_reg     <= cmd.grant && cmd.steal;
            legato_out_reg <= cmd.grant && cmd.steal && leg_cond;
        end
    end

    assign granted      = granted_reg;
    assign chosen_voice = chosen_reg;
    assign trigger      = trigger_reg;
    assign note_key     = note_key_reg;
    assign stolen       = stolen_reg;
    assign legato       = legato_out_reg;

endmodule

`default_nettype wire

FILE: src/round_robin_voice_allocator.sv
// A voice-entry write or an out-of-range group is settled in the setup state, which raises the registered done.
// A note request checks one voice per cycle, first pass then second pass over 12 voices;
// done is registered from the check that hits, or from the last check of the second pass.
// One transaction at a time; start is taken again in the done cycle.
// Reset: async active low; clears the voice table, group pointers and configuration at once.
// Results are valid for the single done cycle and cannot be stalled.
`default_nettype none

module round_robin_voice_allocator
    import rrva_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 action,
    input  wire logic [GROUP_W-1:0]   group,
    input  wire logic [PORT_W-1:0]    port,
    input  wire logic [CHANNEL_W-1:0] channel,
    input  wire logic [KEY_W-1:0]     key,
    input  wire logic [VOICE_W-1:0]   voice_index,
    input  wire logic                 entry_assigned,
    input  wire logic                 entry_held,
    input  wire logic [TRIG_W-1:0]    entry_trigger,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MAP_W-1:0]     cfg_data,
    output logic                      done,
    output logic                      granted,
    output logic [VOICE_W-1:0]        chosen_voice,
    output logic [TRIG_W-1:0]         trigger,
    output logic [KEY_W-1:0]          note_key,
    output logic                      stolen,
    output logic                      legato
);

    rrva_cmd_t    cmd;
    rrva_status_t status;
    logic         start_ok;
    logic         cfg_we;

    // configuration registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign start_ok  = start && !busy;

    rrva_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ok),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rrva_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .action         (action),
        .group          (group),
        .port           (port),
        .channel        (channel),
        .key            (key),
        .voice_index    (voice_index),
        .entry_assigned (entry_assigned),
        .entry_held     (entry_held),
        .entry_trigger  (entry_trigger),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .granted        (granted),
        .chosen_voice   (chosen_voice),
        .trigger        (trigger),
        .note_key       (note_key),
        .stolen         (stolen),
        .legato         (legato)
    );

endmodule

`default_nettype wire

FILE: src/rrva_checker.sv
// port-level checker of the voice allocator, bound to the top level
// depends on rrva_pkg and round_robin_voice_allocator_assert.svh
`default_nettype none

`include "round_robin_voice_allocator_assert.svh"

module rrva_checker
    import rrva_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic               granted,
    input wire logic [VOICE_W-1:0] chosen_voice,
    input wire logic               stolen,
    input wire logic               legato
);

    // an accepted transaction keeps the block busy the next cycle
    `RRVA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // the result strobe comes as the block frees up
    `RRVA_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    // a granted voice is a real voice
    `RRVA_ASSERT_IMP(a_voice_range, clk, rst_n, done && granted,
                     chosen_voice <= VOICE_W'(NUM_VOICES - 1))
    // legato only on a steal, and no steal without a grant
    `RRVA_ASSERT_IMP(a_legato_steal, clk, rst_n, done && (legato || stolen),
                     granted && (stolen || !legato))

endmodule

bind round_robin_voice_allocator rrva_checker u_checker (.*);

`default_nettype wire

FILE: test/tb_round_robin_voice_allocator.sv
// self-checking testbench for round_robin_voice_allocator
// depends on rrva_pkg and the allocator rtl; holds its own allocation predictor
`timescale 1ns / 1ps

module tb_round_robin_voice_allocator;
    import rrva_pkg::*;

    // one request as it is driven on the command ports
    typedef struct packed {
        logic                 action;
        logic [GROUP_W-1:0]   group;
        logic [PORT_W-1:0]    port;
        logic [CHANNEL_W-1:0] channel;
        logic [KEY_W-1:0]     key;
        logic [VOICE_W-1:0]   voice_index;
        logic                 entry_assigned;
        logic                 entry_held;
        logic [TRIG_W-1:0]    entry_trigger;
    } voice_cmd_t;

    // one result as seen on the done strobe
    typedef struct packed {
        logic                 granted;
        logic [VOICE_W-1:0]   chosen_voice;
        logic [TRIG_W-1:0]    trigger;
        logic [KEY_W-1:0]     note_key;
        logic                 stolen;
        logic                 legato;
    } voice_grant_t;

    // voice table mirror, grant predictor and queue of grants still due
    class voice_book;
        logic [MAP_W-1:0]    group_map;
        logic [LEGATO_W-1:0] legato_mask;
        logic [TRIG_W-1:0]   trig_tab [NUM_VOICES];
        bit                  assigned_tab [NUM_VOICES];
        bit                  held_tab [NUM_VOICES];
        int                  last_tab [NUM_GROUPS];
        voice_grant_t        grants_due [$];
        int                  fails;

        function new();
            group_map = '0;
            legato_mask = '0;
            fails = 0;
            foreach (trig_tab[v])
            begin
                trig_tab[v] = '0;
                assigned_tab[v] = 0;
                held_tab[v] = 0;
            end
            foreach (last_tab[g])
                last_tab[g] = 0;
        endfunction

        function int pending();
            return grants_due.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] data);
            if (idx == CFG_VOICE_GROUP_MAP)
                group_map = data;
            else if (idx == CFG_LEGATO_GROUPS)
                legato_mask = data[LEGATO_W-1:0];
        endfunction

        function int wrap_next(int v);
            return (v + 1 > NUM_VOICES - 1) ? 0 : v + 1;
        endfunction

        // predict the grant of one accepted transaction and update the table
        function void note_request(voice_cmd_t c);
            voice_grant_t     res;
            logic [TRIG_W-1:0] trg;
            int               vp;
            int               want;
            bit               found;
            bit               steal;
            bit               leg;
            res = '0;
            found = 0;
            steal = 0;
            leg = 0;
            if (c.action == ACT_WRITE)
            begin
                if (c.voice_index < NUM_VOICES)
                begin
                    assigned_tab[c.voice_index] = c.entry_assigned;
                    held_tab[c.voice_index] = c.entry_held;
                    trig_tab[c.voice_index] = c.entry_trigger;
                end
            end
            else
            begin
                trg = {c.port, c.channel, c.key};
                res.trigger = trg;
                res.note_key = c.key;
                if (c.group < NUM_GROUPS)
                begin
                    want = int'(c.group) + 1;
                    vp = last_tab[c.group] + 1;
                    if (vp > NUM_VOICES - 1)
                        vp = 0;
                    // first pass: free voice of the group
                    for (int i = 0; i < NUM_VOICES && !found; i++)
                    begin
                        if (!assigned_tab[vp] && group_map[MAP_NIB_W*vp +: MAP_NIB_W] == want)
                            found = 1;
                        else
                            vp = wrap_next(vp);
                    end
                    // second pass: steal a released voice of the group
                    for (int i = 0; i < NUM_VOICES && !found; i++)
                    begin
                        if ((!assigned_tab[vp] || !held_tab[vp]) &&
                            group_map[MAP_NIB_W*vp +: MAP_NIB_W] == want)
                        begin
                            found = 1;
                            steal = 1;
                            leg = legato_mask[c.group] && assigned_tab[vp] &&
                                  trig_tab[vp] != trg;
                        end
                        else
                            vp = wrap_next(vp);
                    end
                    if (found)
                    begin
                        last_tab[c.group] = vp;
                        assigned_tab[vp] = 1;
                        held_tab[vp] = 1;
                        trig_tab[vp] = trg;
                        res.granted = 1'b1;
                        res.chosen_voice = VOICE_W'(vp);
                        res.stolen = steal;
                        res.legato = leg;
                    end
                end
            end
            grants_due.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (want_v !== got_v)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want_v, got_v);
                fails++;
            end
        endfunction

        // compare one result with the oldest prediction
        function void check_result(voice_grant_t got);
            voice_grant_t want;
            if (grants_due.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual granted=%0d voice=%0d",
                         $time, got.granted, got.chosen_voice);
                fails++;
                return;
            end
            want = grants_due.pop_front();
            compare_field("granted", 16'(want.granted), 16'(got.granted));
            compare_field("chosen_voice", 16'(want.chosen_voice), 16'(got.chosen_voice));
            compare_field("trigger", 16'(want.trigger), 16'(got.trigger));
            compare_field("note_key", 16'(want.note_key), 16'(got.note_key));
            compare_field("stolen", 16'(want.stolen), 16'(got.stolen));
            compare_field("legato", 16'(want.legato), 16'(got.legato));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 action;
    logic [GROUP_W-1:0]   group;
    logic [PORT_W-1:0]    port;
    logic [CHANNEL_W-1:0] channel;
    logic [KEY_W-1:0]     key;
    logic [VOICE_W-1:0]   voice_index;
    logic                 entry_assigned;
    logic                 entry_held;
    logic [TRIG_W-1:0]    entry_trigger;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MAP_W-1:0]     cfg_data;
    logic                 done;
    logic                 granted;
    logic [VOICE_W-1:0]   chosen_voice;
    logic [TRIG_W-1:0]    trigger;
    logic [KEY_W-1:0]     note_key;
    logic                 stolen;
    logic                 legato;

    voice_book            book;
    logic [GROUP_W-1:0]   hot_groups [4];
    int                   hot_count;
    logic [TRIG_W-1:0]    note_pool [4];

    round_robin_voice_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .group          (group),
        .port           (port),
        .channel        (channel),
        .key            (key),
        .voice_index    (voice_index),
        .entry_assigned (entry_assigned),
        .entry_held     (entry_held),
        .entry_trigger  (entry_trigger),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .granted        (granted),
        .chosen_voice   (chosen_voice),
        .trigger        (trigger),
        .note_key       (note_key),
        .stolen         (stolen),
        .legato         (legato)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin : watch_results
        voice_grant_t seen;
        if (rst_n && done)
        begin
            seen.granted = granted;
            seen.chosen_voice = chosen_voice;
            seen.trigger = trigger;
            seen.note_key = note_key;
            seen.stolen = stolen;
            seen.legato = legato;
            book.check_result(seen);
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic voice_cmd_t note_cmd(int g, int p, int ch, int k);
        voice_cmd_t c;
        c = '0;
        c.action = ACT_ASSIGN;
        c.group = GROUP_W'(g);
        c.port = PORT_W'(p);
        c.channel = CHANNEL_W'(ch);
        c.key = KEY_W'(k);
        return c;
    endfunction

    function automatic voice_cmd_t entry_cmd(int v, int a, int h, int trg);
        voice_cmd_t c;
        c = '0;
        c.action = ACT_WRITE;
        c.voice_index = VOICE_W'(v);
        c.entry_assigned = 1'(a);
        c.entry_held = 1'(h);
        c.entry_trigger = TRIG_W'(trg);
        return c;
    endfunction

    // map with voices spread over a few busy groups
    function automatic logic [MAP_W-1:0] random_map();
        logic [MAP_W-1:0] m;
        int               roll;
        m = '0;
        hot_count = $urandom_range(1, 4);
        for (int g = 0; g < 4; g++)
            hot_groups[g] = GROUP_W'($urandom_range(0, NUM_GROUPS - 1));
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 8)
                m[MAP_NIB_W*v +: MAP_NIB_W] =
                    MAP_NIB_W'(hot_groups[$urandom_range(0, hot_count - 1)]) + MAP_NIB_W'(1);
            else if (roll == 9)
                m[MAP_NIB_W*v +: MAP_NIB_W] = MAP_NIB_W'($urandom_range(NUM_GROUPS + 1, 15));
        end
        return m;
    endfunction

    // note requests, mostly from the busy groups, mixed with host entry writes
    function automatic voice_cmd_t random_item();
        voice_cmd_t  c;
        logic [63:0] raw;
        int          roll;
        raw = {$urandom, $urandom};
        c = raw[$bits(voice_cmd_t)-1:0];
        roll = $urandom_range(0, 99);
        c.action = (roll < 60) ? ACT_ASSIGN : ACT_WRITE;
        if (c.action == ACT_ASSIGN)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                c.group = hot_groups[$urandom_range(0, hot_count - 1)];
            else if (roll < 95)
                c.group = GROUP_W'($urandom_range(0, NUM_GROUPS - 1));
            else
                c.group = GROUP_W'($urandom_range(NUM_GROUPS, 15));
            if ($urandom_range(0, 1))
                {c.port, c.channel, c.key} = note_pool[$urandom_range(0, 3)];
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                c.voice_index = VOICE_W'($urandom_range(NUM_VOICES, 15));
            else
                c.voice_index = VOICE_W'($urandom_range(0, NUM_VOICES - 1));
            roll = $urandom_range(0, 9);
            // mostly key releases, some frees, some arbitrary entries
            if (roll < 5)
            begin
                c.entry_assigned = 1'b1;
                c.entry_held = 1'b0;
            end
            else if (roll < 8)
                c.entry_assigned = 1'b0;
            if ($urandom_range(0, 1))
                c.entry_trigger = note_pool[$urandom_range(0, 3)];
        end
        return c;
    endfunction

    // config register write on its own channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAP_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        book.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one command transaction, after an idle gap when gap is nonzero
    task automatic send_item(input voice_cmd_t c, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        action <= c.action;
        group <= c.group;
        port <= c.port;
        channel <= c.channel;
        key <= c.key;
        voice_index <= c.voice_index;
        entry_assigned <= c.entry_assigned;
        entry_held <= c.entry_held;
        entry_trigger <= c.entry_trigger;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        book.note_request(c);
    endtask

    // hold off until every predicted grant has been seen
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        logic [MAP_W-1:0]    map_val;
        logic [LEGATO_W-1:0] leg_val;
        voice_cmd_t          directed [$];
        int                  n_items;
        int                  gap;
        book = new();
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_ASSIGN;
        group = '0;
        port = '0;
        channel = '0;
        key = '0;
        voice_index = '0;
        entry_assigned = 1'b0;
        entry_held = 1'b0;
        entry_trigger = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_VOICE_GROUP_MAP;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // voices 0-3 group 0, 4-7 group 1, 8 group 11, 11 group 2, 9-10 unowned
        write_reg(CFG_VOICE_GROUP_MAP, 48'h300C_2222_1111);
        write_reg(CFG_LEGATO_GROUPS, MAP_W'(12'h001));

        // fill group 0, then miss with every voice held
        directed.push_back(note_cmd(0, 3, 15, 127));
        directed.push_back(note_cmd(0, 0, 0, 0));
        directed.push_back(note_cmd(0, 1, 5, 60));
        directed.push_back(note_cmd(0, 2, 10, 64));
        directed.push_back(note_cmd(0, 1, 1, 1));
        // steal of a released voice holding the same note: no legato
        directed.push_back(entry_cmd(2, 1, 0, 0));
        directed.push_back(note_cmd(0, 0, 0, 0));
        // steal of a released voice holding another note: legato
        directed.push_back(entry_cmd(3, 1, 0, 8191));
        directed.push_back(note_cmd(0, 0, 0, 5));
        // held mark on an unassigned voice is ignored
        directed.push_back(entry_cmd(1, 0, 1, 100));
        directed.push_back(note_cmd(0, 2, 3, 4));
        // single-voice group, no legato enabled
        directed.push_back(note_cmd(11, 1, 2, 3));
        directed.push_back(note_cmd(11, 3, 3, 3));
        directed.push_back(entry_cmd(8, 1, 0, 77));
        directed.push_back(note_cmd(11, 0, 7, 90));
        // groups without a pointer slot and writes past the last voice
        directed.push_back(note_cmd(12, 1, 1, 1));
        directed.push_back(note_cmd(15, 2, 2, 2));
        directed.push_back(entry_cmd(12, 1, 1, 8191));
        directed.push_back(entry_cmd(15, 1, 1, 4095));
        // pointer at the last voice wraps the search to voice 0
        directed.push_back(note_cmd(2, 0, 9, 33));
        directed.push_back(entry_cmd(11, 0, 0, 0));
        directed.push_back(note_cmd(2, 0, 9, 34));
        directed.push_back(note_cmd(1, 3, 0, 127));
        foreach (directed[i])
            send_item(directed[i], $urandom_range(0, 3));
        drain_results();

        // random phases, each under its own configuration
        for (int ph = 0; ph < 8; ph++)
        begin
            map_val = random_map();
            leg_val = LEGATO_W'($urandom_range(0, 4095));
            n_items = 85;
            if (ph == 0)
            begin
                map_val = '0;
                leg_val = '0;
                n_items = 25;
            end
            else if (ph == 1)
            begin
                map_val = '1;
                leg_val = '1;
                n_items = 25;
            end
            else if (ph == 2)
                leg_val = '1;
            else if (ph == 3)
                leg_val = '0;
            for (int i = 0; i < 4; i++)
                note_pool[i] = TRIG_W'($urandom_range(0, 8191));
            write_reg(CFG_VOICE_GROUP_MAP, map_val);
            write_reg(CFG_LEGATO_GROUPS, MAP_W'(leg_val));
            for (int i = 0; i < n_items; i++)
            begin
                gap = (ph % 3 == 0) ? 0 : $urandom_range(0, 3);
                send_item(random_item(), gap);
            end
            drain_results();
        end

        repeat (30) @(posedge clk);
        if (book.fails == 0 && book.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: round_robin_voice_allocator.f
+incdir+src
src/rrva_pkg.sv
src/rrva_ctrl.sv
src/rrva_datapath.sv
src/round_robin_voice_allocator.sv
src/rrva_checker.sv
test/tb_round_robin_voice_allocator.sv
